@@ rtl/crlf_pkg.sv @@
`default_nettype none

package crlf_pkg;

	localparam int TAPS = 1024;
	localparam int SLOT_W = $clog2(TAPS);
	localparam int FILL_W = $clog2(TAPS + 1);
	localparam int TERM_W = 48;
	localparam int SUM_W = TERM_W + SLOT_W;
	localparam int EST_W = 64;
	localparam int DIV_STEPS = 48;
	localparam int CNT_W = $clog2(DIV_STEPS);

	localparam logic [31:0] GAIN_RESET = 32'd429497;
	localparam logic [TERM_W-1:0] TERM_POS_LIMIT = 48'h7FFF_FFFF_FFFF;
	localparam logic [TERM_W-1:0] TERM_NEG_LIMIT = 48'h8000_0000_0000;

	typedef struct packed {
		logic signed [31:0] measured_offset;
		logic [31:0] tick_interval;
	} in_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] freq_error;
		logic signed [EST_W-1:0] offset_estimate;
	} out_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DRIFT,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_PROD,
		ST_TDIV_LOAD,
		ST_TDIV,
		ST_TERM,
		ST_FDIV_LOAD,
		ST_FDIV,
		ST_FREQ,
		ST_DMUL_HI,
		ST_DMUL_LO,
		ST_DSUM,
		ST_EST,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DRIFT,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_PROD,
		OP_TDIV_LOAD,
		OP_DIV_STEP,
		OP_TERM,
		OP_FDIV_LOAD,
		OP_FREQ,
		OP_DMUL_HI,
		OP_DMUL_LO,
		OP_DSUM,
		OP_EST,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} status_t;

endpackage

`default_nettype wire

@@ rtl/crlf_ctrl.sv @@
`default_nettype none

module crlf_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire logic result_stall,
	input wire crlf_pkg::status_t status,
	output crlf_pkg::cmd_t cmd
);

	crlf_pkg::state_t state_q;
	crlf_pkg::state_t state_d;
	logic [crlf_pkg::CNT_W-1:0] cnt_q;
	logic last_step;
	logic out_free;

	assign last_step = (cnt_q == crlf_pkg::CNT_W'(crlf_pkg::DIV_STEPS - 1));
	assign out_free = !status.out_full || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crlf_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == crlf_pkg::ST_TDIV_LOAD || state_q == crlf_pkg::ST_FDIV_LOAD) begin
				cnt_q <= '0;
			end else if (state_q == crlf_pkg::ST_TDIV || state_q == crlf_pkg::ST_FDIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			crlf_pkg::ST_IDLE: begin
				if (item_valid) state_d = crlf_pkg::ST_DRIFT;
			end
			crlf_pkg::ST_DRIFT: state_d = crlf_pkg::ST_MUL_LO;
			crlf_pkg::ST_MUL_LO: state_d = crlf_pkg::ST_MUL_HI;
			crlf_pkg::ST_MUL_HI: state_d = crlf_pkg::ST_PROD;
			crlf_pkg::ST_PROD: state_d = crlf_pkg::ST_TDIV_LOAD;
			crlf_pkg::ST_TDIV_LOAD: state_d = crlf_pkg::ST_TDIV;
			crlf_pkg::ST_TDIV: begin
				if (last_step) state_d = crlf_pkg::ST_TERM;
			end
			crlf_pkg::ST_TERM: state_d = crlf_pkg::ST_FDIV_LOAD;
			crlf_pkg::ST_FDIV_LOAD: state_d = crlf_pkg::ST_FDIV;
			crlf_pkg::ST_FDIV: begin
				if (last_step) state_d = crlf_pkg::ST_FREQ;
			end
			crlf_pkg::ST_FREQ: state_d = crlf_pkg::ST_DMUL_HI;
			crlf_pkg::ST_DMUL_HI: state_d = crlf_pkg::ST_DMUL_LO;
			crlf_pkg::ST_DMUL_LO: state_d = crlf_pkg::ST_DSUM;
			crlf_pkg::ST_DSUM: state_d = crlf_pkg::ST_EST;
			crlf_pkg::ST_EST: state_d = crlf_pkg::ST_OUT;
			crlf_pkg::ST_OUT: begin
				if (out_free) state_d = crlf_pkg::ST_IDLE;
			end
			default: state_d = crlf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall = (state_q != crlf_pkg::ST_IDLE);
		cmd.op = crlf_pkg::OP_NONE;
		case (state_q)
			crlf_pkg::ST_IDLE: begin
				if (item_valid) cmd.op = crlf_pkg::OP_LOAD;
			end
			crlf_pkg::ST_DRIFT: cmd.op = crlf_pkg::OP_DRIFT;
			crlf_pkg::ST_MUL_LO: cmd.op = crlf_pkg::OP_MUL_LO;
			crlf_pkg::ST_MUL_HI: cmd.op = crlf_pkg::OP_MUL_HI;
			crlf_pkg::ST_PROD: cmd.op = crlf_pkg::OP_PROD;
			crlf_pkg::ST_TDIV_LOAD: cmd.op = crlf_pkg::OP_TDIV_LOAD;
			crlf_pkg::ST_TDIV: cmd.op = crlf_pkg::OP_DIV_STEP;
			crlf_pkg::ST_TERM: cmd.op = crlf_pkg::OP_TERM;
			crlf_pkg::ST_FDIV_LOAD: cmd.op = crlf_pkg::OP_FDIV_LOAD;
			crlf_pkg::ST_FDIV: cmd.op = crlf_pkg::OP_DIV_STEP;
			crlf_pkg::ST_FREQ: cmd.op = crlf_pkg::OP_FREQ;
			crlf_pkg::ST_DMUL_HI: cmd.op = crlf_pkg::OP_DMUL_HI;
			crlf_pkg::ST_DMUL_LO: cmd.op = crlf_pkg::OP_DMUL_LO;
			crlf_pkg::ST_DSUM: cmd.op = crlf_pkg::OP_DSUM;
			crlf_pkg::ST_EST: cmd.op = crlf_pkg::OP_EST;
			crlf_pkg::ST_OUT: begin
				if (out_free) cmd.op = crlf_pkg::OP_OUT;
			end
			default: cmd.op = crlf_pkg::OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/crlf_dp.sv @@
`default_nettype none

module crlf_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire crlf_pkg::cmd_t cmd,
	input wire crlf_pkg::in_t item,
	input wire logic cfg_wr_en,
	input wire logic [31:0] cfg_wr_data,
	input wire logic result_stall,
	output crlf_pkg::status_t status,
	output logic result_valid,
	output crlf_pkg::out_t result
);

	localparam int TW = crlf_pkg::TERM_W;
	localparam int SW = crlf_pkg::SUM_W;

	function automatic logic [63:0] sat64(input logic [64:0] v);
		logic [63:0] r;
		if (v[64] != v[63]) begin
			r = v[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end else begin
			r = v[63:0];
		end
		return r;
	endfunction

	// Loop state.
	logic [31:0] gain_q;
	logic signed [63:0] est_q;
	logic started_q;
	logic signed [SW-1:0] sum_q;
	logic [crlf_pkg::SLOT_W-1:0] slot_q;
	logic [crlf_pkg::FILL_W-1:0] fill_q;
	logic out_full_q;

	// Working registers of one transaction.
	logic [63:0] measq_q;
	logic [31:0] ticks_q;
	logic [63:0] mag_q;
	logic neg_q;
	logic [63:0] mul_q;
	logic [95:0] acc_q;
	logic [31:0] rem_q;
	logic [TW-1:0] dq_q;
	logic [31:0] dvs_q;
	logic ovf_q;
	logic [TW-1:0] freq_q;
	crlf_pkg::out_t out_q;
	logic [TW-1:0] rd_q;

	logic [TW-1:0] hist_mem [crlf_pkg::TAPS];

	logic [63:0] meas_ext;
	logic [31:0] ticks_in;
	logic [64:0] diff;
	logic [63:0] drift;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;
	logic [TW-1:0] limit;
	logic [TW-1:0] term_mag;
	logic [TW-1:0] term;
	logic [TW-1:0] old_term;
	logic hist_full;
	logic [SW-1:0] sum_mag;
	logic [64:0] dm_ext;
	logic [64:0] delta;
	logic [64:0] est_sum;

	assign meas_ext = {{16{item.measured_offset[31]}}, item.measured_offset, 16'h0000};
	assign ticks_in = (item.tick_interval == 32'd0) ? 32'd1 : item.tick_interval;
	assign diff = {measq_q[63], measq_q} - {est_q[63], est_q};
	assign drift = sat64(diff);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			crlf_pkg::OP_MUL_LO: begin
				mul_a = gain_q;
				mul_b = mag_q[31:0];
			end
			crlf_pkg::OP_MUL_HI: begin
				mul_a = gain_q;
				mul_b = mag_q[63:32];
			end
			crlf_pkg::OP_DMUL_HI: begin
				mul_a = {8'h00, dq_q[47:24]};
				mul_b = ticks_q;
			end
			crlf_pkg::OP_DMUL_LO: begin
				mul_a = {8'h00, dq_q[23:0]};
				mul_b = ticks_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = {32'h0, mul_a} * {32'h0, mul_b};

	assign rem_sh = {rem_q, dq_q[TW-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	assign limit = neg_q ? crlf_pkg::TERM_NEG_LIMIT : crlf_pkg::TERM_POS_LIMIT;
	assign term_mag = (ovf_q || (dq_q > limit)) ? limit : dq_q;
	assign term = neg_q ? -term_mag : term_mag;
	assign hist_full = (fill_q == crlf_pkg::FILL_W'(crlf_pkg::TAPS));
	assign old_term = hist_full ? rd_q : '0;

	assign sum_mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);

	assign dm_ext = {8'h00, acc_q[56:0]};
	assign delta = neg_q ? -dm_ext : dm_ext;
	assign est_sum = {est_q[63], est_q} + delta;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= crlf_pkg::GAIN_RESET;
			est_q <= '0;
			started_q <= 1'b0;
			sum_q <= '0;
			slot_q <= '0;
			fill_q <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (cfg_wr_en) gain_q <= cfg_wr_data;
			if (cmd.op == crlf_pkg::OP_LOAD && !started_q) begin
				est_q <= meas_ext;
				started_q <= 1'b1;
			end
			if (cmd.op == crlf_pkg::OP_TERM) begin
				sum_q <= sum_q - {{(SW - TW){old_term[TW-1]}}, old_term}
					+ {{(SW - TW){term[TW-1]}}, term};
				slot_q <= (slot_q == crlf_pkg::SLOT_W'(crlf_pkg::TAPS - 1)) ? '0 : slot_q + 1'b1;
				if (!hist_full) fill_q <= fill_q + 1'b1;
			end
			if (cmd.op == crlf_pkg::OP_EST) est_q <= sat64(est_sum);
			if (cmd.op == crlf_pkg::OP_OUT) begin
				out_full_q <= 1'b1;
			end else if (!result_stall) begin
				out_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			crlf_pkg::OP_LOAD: begin
				measq_q <= meas_ext;
				ticks_q <= ticks_in;
			end
			crlf_pkg::OP_DRIFT: begin
				neg_q <= drift[63];
				mag_q <= drift[63] ? -drift : drift;
			end
			crlf_pkg::OP_MUL_LO: mul_q <= mul_p;
			crlf_pkg::OP_MUL_HI: begin
				acc_q <= {32'h0, mul_q};
				mul_q <= mul_p;
			end
			crlf_pkg::OP_PROD: acc_q <= acc_q + {mul_q, 32'h0};
			crlf_pkg::OP_TDIV_LOAD: begin
				ovf_q <= (acc_q[95:55] >= {9'h000, ticks_q});
				rem_q <= acc_q[86:55];
				dq_q <= acc_q[54:7];
				dvs_q <= ticks_q;
			end
			crlf_pkg::OP_DIV_STEP: begin
				if (!rem_sub[32]) begin
					rem_q <= rem_sub[31:0];
					dq_q <= {dq_q[TW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[31:0];
					dq_q <= {dq_q[TW-2:0], 1'b0};
				end
			end
			crlf_pkg::OP_FDIV_LOAD: begin
				neg_q <= sum_q[SW-1];
				rem_q <= {{(32 - (SW - TW)){1'b0}}, sum_mag[SW-1:TW]};
				dq_q <= sum_mag[TW-1:0];
				dvs_q <= {{(32 - crlf_pkg::FILL_W){1'b0}}, fill_q};
			end
			crlf_pkg::OP_FREQ: freq_q <= neg_q ? -dq_q : dq_q;
			crlf_pkg::OP_DMUL_HI: mul_q <= mul_p;
			crlf_pkg::OP_DMUL_LO: begin
				acc_q <= {32'h0, mul_q};
				mul_q <= mul_p;
			end
			crlf_pkg::OP_DSUM: acc_q <= acc_q + {56'h0, mul_q[63:24]};
			crlf_pkg::OP_OUT: begin
				out_q.freq_error <= freq_q;
				out_q.offset_estimate <= est_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == crlf_pkg::OP_TERM) hist_mem[slot_q] <= term;
		rd_q <= hist_mem[slot_q];
	end

	assign status.out_full = out_full_q;
	assign result_valid = out_full_q;
	assign result = out_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= crlf_pkg::FILL_W'(crlf_pkg::TAPS))
		else $error("History fill count exceeds the ring depth.");

	a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!hist_full |-> (slot_q == fill_q[crlf_pkg::SLOT_W-1:0]))
		else $error("Ring position and fill count disagree before the ring wraps.");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == crlf_pkg::OP_OUT) |-> (!out_full_q || !result_stall))
		else $error("Result register overwritten while a transaction is pending.");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == crlf_pkg::OP_DIV_STEP) |-> (dvs_q != 32'd0))
		else $error("Divider runs with a zero divisor.");

	a_started_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(started_q))
		else $error("Started flag cleared outside reset.");
`endif

endmodule

`default_nettype wire

@@ rtl/clock_recovery_loop_filter_top.sv @@
`default_nettype none

// Clock recovery loop filter. Each input transaction carries a measured offset (local minus
// source count) and the local ticks since the previous timestamp; each produces exactly one
// result transaction with the moving-average frequency error (Q7.40) and the updated offset
// estimate (Q47.16). One transaction is processed at a time; the next is accepted only once
// the previous result is in the result register. The shared 32x32 multiplier forms four
// products and the shared bit-serial divider runs 48 steps for the loop term and 48 for the
// average. The 1024-entry history lives in one on-chip memory; until the ring has filled, the
// entry read back counts as zero, so no clearing pass follows reset.
// The loop gain register may only be written while no transaction is in flight.

module clock_recovery_loop_filter_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire crlf_pkg::in_t item,
	output logic result_valid,
	input wire logic result_stall,
	output crlf_pkg::out_t result,
	input wire logic cfg_wr_en,
	input wire logic [31:0] cfg_wr_data
);

	crlf_pkg::cmd_t cmd;
	crlf_pkg::status_t status;

	crlf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.result_stall(result_stall),
		.status(status),
		.cmd(cmd)
	);

	crlf_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.item(item),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.result_stall(result_stall),
		.status(status),
		.result_valid(result_valid),
		.result(result)
	);

endmodule

`default_nettype wire
